[rtl/overlay_range_table_defines.svh]
// Assertion macros shared by the overlay range table RTL.
// Included by the controller and datapath modules; no other dependencies.
`ifndef OVERLAY_RANGE_TABLE_DEFINES_SVH
`define OVERLAY_RANGE_TABLE_DEFINES_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define ORT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("overlay range table: same-cycle check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define ORT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("overlay range table: next-cycle check failed");

`endif

[rtl/ort_pkg.sv]
// Shared types and constants for the overlay range table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ort_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 16;

   localparam int OP_W    = 2;
   localparam int TAG_W   = 32;
   localparam int FOFF_W  = 32;
   localparam int SEG_W   = 16;
   localparam int BOFF_W  = 16;
   localparam int LEN_W   = 16;
   localparam int ADDR_W  = 21;
   localparam int GEN_W   = 32;
   localparam int INDEX_W = 4;
   localparam int COUNT_W = 5;

   localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

   typedef struct packed {
      logic [ADDR_W-1:0] first_byte;
      logic [ADDR_W-1:0] last_byte;
      logic [TAG_W-1:0]  file_tag;
      logic [FOFF_W-1:0] src_offset;
      logic [LEN_W-1:0]  length;
      logic [GEN_W-1:0]  generation;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic gen_inc;
      logic clear_table;
      logic pass_start;
      logic pass_evict;
      logic pass_step;
      logic pass_commit;
      logic look_start;
      logic look_step;
      logic append;
      logic load_rsp;
   } ort_cmd_type;

   typedef struct packed {
      logic is_record;
      logic is_lookup;
      logic is_clear;
      logic len_zero;
      logic resident;
      logic pass_done;
      logic look_done;
      logic full;
   } ort_status_type;

endpackage

[rtl/ort_datapath.sv]
// Datapath of the overlay range table: entry memory, scan pointers, counters
// and result registers. Depends on ort_pkg and overlay_range_table_defines.svh.
`timescale 1ns / 1ps
`include "overlay_range_table_defines.svh"

module ort_datapath
   import ort_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ort_cmd_type          cmd,
   output ort_status_type       status,
   input  logic [OP_W-1:0]      req_operation,
   input  logic [TAG_W-1:0]     req_file_tag,
   input  logic [FOFF_W-1:0]    req_file_offset,
   input  logic [SEG_W-1:0]     req_segment,
   input  logic [BOFF_W-1:0]    req_buffer_offset,
   input  logic [LEN_W-1:0]     req_read_length,
   input  logic                 req_resident_image,
   output logic                 rsp_found,
   output logic [INDEX_W-1:0]   rsp_entry_index,
   output logic [GEN_W-1:0]     rsp_entry_generation,
   output logic [COUNT_W-1:0]   rsp_entry_count
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   // captured request
   logic [OP_W-1:0]   op_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic [FOFF_W-1:0] foff_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [ADDR_W-1:0] first_ff;
   logic [ADDR_W-1:0] last_ff;
   logic              resident_ff;

   // table state and scan control
   logic [CNT_W-1:0]  count_ff;
   logic [GEN_W-1:0]  gen_ff;
   logic [CNT_W-1:0]  rd_idx_ff;
   logic [IDX_W-1:0]  rd_pos_ff;
   logic              rd_valid_ff;
   logic [CNT_W-1:0]  kept_ff;
   logic              evict_ff;
   logic              found_ff;
   logic [IDX_W-1:0]  hit_index_ff;
   logic [GEN_W-1:0]  hit_gen_ff;

   entry_type         mem [MAX_ENTRIES];
   entry_type         rd_data_ff;

   // output registers
   logic               rsp_found_ff;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic [GEN_W-1:0]   rsp_gen_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic [ADDR_W-1:0] first_in;
   logic [ADDR_W-1:0] last_in;
   logic              overlap;
   logic              drop;
   logic              rd_fwd;
   logic              rd_back;
   logic              look_hit;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   entry_type         wr_data;
   entry_type         new_entry;

   assign first_in = ADDR_W'({req_segment, 4'b0000}) + ADDR_W'(req_buffer_offset);
   assign last_in  = first_ff + ADDR_W'(len_ff) - ADDR_W'(1);

   assign overlap  = (rd_data_ff.first_byte <= last_ff) && (first_ff <= rd_data_ff.last_byte);
   assign drop     = evict_ff ? (rd_pos_ff == '0) : overlap;
   assign rd_fwd   = rd_idx_ff < count_ff;
   assign rd_back  = rd_idx_ff != '0;
   assign look_hit = rd_valid_ff && (rd_data_ff.file_tag == tag_ff)
                     && (rd_data_ff.src_offset == foff_ff) && (rd_data_ff.length == len_ff);

   always_comb begin
      new_entry.first_byte  = first_ff;
      new_entry.last_byte   = last_ff;
      new_entry.file_tag    = tag_ff;
      new_entry.src_offset  = foff_ff;
      new_entry.length      = len_ff;
      new_entry.generation  = gen_ff;
   end

   assign rd_en   = (cmd.pass_step && rd_fwd) || (cmd.look_step && rd_back);
   assign rd_addr = cmd.look_step ? IDX_W'(rd_idx_ff - CNT_W'(1)) : IDX_W'(rd_idx_ff);
   assign wr_en   = (cmd.pass_step && rd_valid_ff && !drop) || cmd.append;
   assign wr_addr = cmd.append ? IDX_W'(count_ff) : IDX_W'(kept_ff);
   assign wr_data = cmd.append ? new_entry : rd_data_ff;

   always_comb begin
      status.is_record = op_ff == OP_RECORD;
      status.is_lookup = op_ff == OP_LOOKUP;
      status.is_clear  = op_ff == OP_CLEAR;
      status.len_zero  = len_ff == '0;
      status.resident  = resident_ff;
      status.pass_done = (rd_idx_ff == count_ff) && !rd_valid_ff;
      status.look_done = look_hit || (!rd_back && !rd_valid_ff);
      status.full      = count_ff >= CNT_W'(MAX_ENTRIES);
   end

   // entry memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= req_operation;
         tag_ff      <= req_file_tag;
         foff_ff     <= req_file_offset;
         len_ff      <= req_read_length;
         first_ff    <= first_in;
         resident_ff <= req_resident_image;
      end
      if (cmd.gen_inc) begin
         last_ff <= last_in;
      end
      if (cmd.look_step && look_hit) begin
         hit_index_ff <= rd_pos_ff;
         hit_gen_ff   <= rd_data_ff.generation;
      end
      if (cmd.load_rsp) begin
         rsp_found_ff <= found_ff;
         rsp_index_ff <= found_ff ? INDEX_W'(hit_index_ff) : '0;
         rsp_gen_ff   <= found_ff ? hit_gen_ff : '0;
         rsp_count_ff <= COUNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         gen_ff      <= '0;
         rd_idx_ff   <= '0;
         rd_pos_ff   <= '0;
         rd_valid_ff <= 1'b0;
         kept_ff     <= '0;
         evict_ff    <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         if (cmd.capture) begin
            found_ff <= 1'b0;
         end
         if (cmd.gen_inc) begin
            gen_ff <= gen_ff + GEN_W'(1);
         end
         if (cmd.clear_table) begin
            count_ff <= '0;
            gen_ff   <= '0;
         end
         if (cmd.pass_start) begin
            rd_idx_ff   <= '0;
            kept_ff     <= '0;
            rd_valid_ff <= 1'b0;
            evict_ff    <= cmd.pass_evict;
         end
         if (cmd.look_start) begin
            rd_idx_ff   <= count_ff;
            rd_valid_ff <= 1'b0;
         end
         if (cmd.pass_step) begin
            rd_valid_ff <= rd_fwd;
            if (rd_fwd) begin
               rd_idx_ff <= rd_idx_ff + CNT_W'(1);
               rd_pos_ff <= IDX_W'(rd_idx_ff);
            end
            if (rd_valid_ff && !drop) begin
               kept_ff <= kept_ff + CNT_W'(1);
            end
         end
         if (cmd.look_step) begin
            rd_valid_ff <= rd_back;
            if (rd_back) begin
               rd_idx_ff <= rd_idx_ff - CNT_W'(1);
               rd_pos_ff <= IDX_W'(rd_idx_ff - CNT_W'(1));
            end
            if (look_hit) begin
               found_ff <= 1'b1;
            end
         end
         if (cmd.pass_commit) begin
            count_ff <= kept_ff;
         end
         if (cmd.append) begin
            count_ff <= count_ff + CNT_W'(1);
         end
      end
   end

   assign rsp_found            = rsp_found_ff;
   assign rsp_entry_index      = rsp_index_ff;
   assign rsp_entry_generation = rsp_gen_ff;
   assign rsp_entry_count      = rsp_count_ff;

   `ORT_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_ENTRIES))
   `ORT_ASSERT_NEXT(a_append_grows, clock, reset, cmd.append, count_ff == $past(count_ff) + CNT_W'(1))
   `ORT_ASSERT_SAME(a_hit_in_table, clock, reset, found_ff, CNT_W'(hit_index_ff) < count_ff)

endmodule

[rtl/ort_controller.sv]
// Sequencing state machine of the overlay range table.
// Depends on ort_pkg and overlay_range_table_defines.svh.
`timescale 1ns / 1ps
`include "overlay_range_table_defines.svh"

module ort_controller
   import ort_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output ort_cmd_type    cmd,
   input  ort_status_type status
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_COMPACT,
      S_EVICT_CHK,
      S_EVICT,
      S_APPEND,
      S_LOOKUP,
      S_RESULT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_RESULT;
            if (status.is_record && !status.len_zero) begin
               cmd.gen_inc    = 1'b1;
               cmd.pass_start = 1'b1;
               state_in       = S_COMPACT;
            end else if (status.is_lookup && !status.resident) begin
               cmd.look_start = 1'b1;
               state_in       = S_LOOKUP;
            end else if (status.is_clear) begin
               cmd.clear_table = 1'b1;
            end
         end
         S_COMPACT: begin
            if (status.pass_done) begin
               cmd.pass_commit = 1'b1;
               state_in        = S_EVICT_CHK;
            end else begin
               cmd.pass_step = 1'b1;
            end
         end
         S_EVICT_CHK: begin
            if (status.full) begin
               cmd.pass_start = 1'b1;
               cmd.pass_evict = 1'b1;
               state_in       = S_EVICT;
            end else begin
               state_in = S_APPEND;
            end
         end
         S_EVICT: begin
            if (status.pass_done) begin
               cmd.pass_commit = 1'b1;
               state_in        = S_APPEND;
            end else begin
               cmd.pass_step = 1'b1;
            end
         end
         S_APPEND: begin
            cmd.append = 1'b1;
            state_in   = S_RESULT;
         end
         S_LOOKUP: begin
            cmd.look_step = 1'b1;
            if (status.look_done) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            cmd.load_rsp = !rsp_valid_ff || !rsp_stall;
            if (cmd.load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   `ORT_ASSERT_NEXT(a_accept_decode, clock, reset, req_valid && !req_stall, state_ff == S_DECODE)
   `ORT_ASSERT_NEXT(a_result_waits, clock, reset, (state_ff == S_RESULT) && !cmd.load_rsp, (state_ff == S_RESULT) && rsp_valid_ff)
   `ORT_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid_ff && rsp_stall, rsp_valid_ff)

endmodule

[rtl/overlay_range_table.sv]
// Top level of the overlay range table: controller plus datapath.
// Depends on ort_pkg, ort_controller and ort_datapath.
`timescale 1ns / 1ps

// Overlay range table. Keeps up to MAX_ENTRIES loaded memory ranges, packed
// oldest first. A record with nonzero length drops every entry whose physical
// byte range (segment*16 + offset, length bytes) overlaps the new one, evicts
// the oldest if the table is still full, and appends the new entry under the
// next generation number. A lookup searches newest first for a matching file
// tag, file offset and length (never matching for a resident image); a clear
// empties the table and zeroes the generation. Every request gives exactly
// one response carrying the entry count after the operation. One request is
// handled at a time, and each table pass reads one entry per cycle from the
// entry memory (one read port, one write port). A new request is taken while a
// finished response still waits in the output register. No clearing pass after
// reset: only filled entries are read.

module overlay_range_table
   import ort_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [OP_W-1:0]    req_operation,
   input  logic [TAG_W-1:0]   req_file_tag,
   input  logic [FOFF_W-1:0]  req_file_offset,
   input  logic [SEG_W-1:0]   req_segment,
   input  logic [BOFF_W-1:0]  req_buffer_offset,
   input  logic [LEN_W-1:0]   req_read_length,
   input  logic               req_resident_image,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_found,
   output logic [INDEX_W-1:0] rsp_entry_index,
   output logic [GEN_W-1:0]   rsp_entry_generation,
   output logic [COUNT_W-1:0] rsp_entry_count
);

   ort_cmd_type    cmd;
   ort_status_type status;

   // Controller: sequences decode, the overlap/eviction compaction passes,
   // the append and the lookup scan, and owns both handshakes.
   ort_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Datapath: request capture, entry memory, scan pointers, entry count,
   // generation counter and the response payload register.
   ort_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_operation        (req_operation),
      .req_file_tag         (req_file_tag),
      .req_file_offset      (req_file_offset),
      .req_segment          (req_segment),
      .req_buffer_offset    (req_buffer_offset),
      .req_read_length      (req_read_length),
      .req_resident_image   (req_resident_image),
      .rsp_found            (rsp_found),
      .rsp_entry_index      (rsp_entry_index),
      .rsp_entry_generation (rsp_entry_generation),
      .rsp_entry_count      (rsp_entry_count)
   );

endmodule

[test/overlay_range_table_tb.sv]
// Self-checking testbench for overlay_range_table: directed rows, then random traffic.
// Depends on ort_pkg and the overlay_range_table RTL; a shadow copy of the range table
// predicts every response but those typed into pinned directed rows.
`timescale 1ns / 1ps

module overlay_range_table_tb;
   import ort_pkg::*;

   localparam int MAX_SLOTS   = MAX_ENTRIES_DEFAULT;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_CYCLES = 300;   // long receiver hold-off
   localparam int TAIL_CYCLES = 60;    // worst record latency, with margin
   localparam int N_DIRECTED  = 25;

   // Operation code the block does not define; must change nothing.
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [TAG_W-1:0]  tag;
      logic [FOFF_W-1:0] foff;
      logic [SEG_W-1:0]  seg;
      logic [BOFF_W-1:0] boff;
      logic [LEN_W-1:0]  len;
      logic              res;
   } range_req_type;

   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] slot;
      logic [GEN_W-1:0]   gen;
      logic [COUNT_W-1:0] count;
   } range_rsp_type;

   typedef struct packed {
      range_req_type req;
      logic          pinned;   // rsp typed in below instead of predicted
      range_rsp_type rsp;
   } stim_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [OP_W-1:0]    req_operation;
   logic [TAG_W-1:0]   req_file_tag;
   logic [FOFF_W-1:0]  req_file_offset;
   logic [SEG_W-1:0]   req_segment;
   logic [BOFF_W-1:0]  req_buffer_offset;
   logic [LEN_W-1:0]   req_read_length;
   logic               req_resident_image;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_found;
   logic [INDEX_W-1:0] rsp_entry_index;
   logic [GEN_W-1:0]   rsp_entry_generation;
   logic [COUNT_W-1:0] rsp_entry_count;

   overlay_range_table u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_operation        (req_operation),
      .req_file_tag         (req_file_tag),
      .req_file_offset      (req_file_offset),
      .req_segment          (req_segment),
      .req_buffer_offset    (req_buffer_offset),
      .req_read_length      (req_read_length),
      .req_resident_image   (req_resident_image),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_found            (rsp_found),
      .rsp_entry_index      (rsp_entry_index),
      .rsp_entry_generation (rsp_entry_generation),
      .rsp_entry_count      (rsp_entry_count)
   );

   // Shadow of the block state
   entry_type          shadow_entry [MAX_SLOTS];
   logic [COUNT_W-1:0] shadow_count;
   logic [GEN_W-1:0]   shadow_gen;

   range_rsp_type table_rsp_q [$];   // responses still owed by the block
   stim_row_type  dir_rows [N_DIRECTED];

   int err_count;
   int cycle_count;
   int idle_mode;                 // 0: no gaps or stalls, 1: random
   int hold_asks, hold_seen;
   int n_records, n_lookups, n_clears, n_spare;
   int n_hits, n_dropped, n_evicted, n_checked, max_fill;

   // 8 ns clock
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Shadow table update: returns the response the block owes for one transfer.
   function automatic range_rsp_type update_shadow_table(range_req_type q);
      range_rsp_type     r;
      logic [ADDR_W-1:0] first_b;
      logic [ADDR_W-1:0] last_b;
      int                kept;
      r = '0;
      case (q.op)
         OP_RECORD: begin
            if (q.len != '0) begin
               shadow_gen = shadow_gen + GEN_W'(1);
               first_b = {1'b0, q.seg, 4'b0000} + ADDR_W'(q.boff);
               last_b  = first_b + ADDR_W'(q.len) - ADDR_W'(1);
               // compact out every overlapping range, keep order
               kept = 0;
               for (int i = 0; i < int'(shadow_count); i++) begin
                  if (shadow_entry[i].first_byte <= last_b &&
                      first_b <= shadow_entry[i].last_byte) begin
                     n_dropped++;
                  end else begin
                     shadow_entry[kept] = shadow_entry[i];
                     kept++;
                  end
               end
               // still full: oldest goes
               if (kept >= MAX_SLOTS) begin
                  for (int i = 1; i < MAX_SLOTS; i++)
                     shadow_entry[i-1] = shadow_entry[i];
                  kept = MAX_SLOTS - 1;
                  n_evicted++;
               end
               shadow_entry[kept].first_byte  = first_b;
               shadow_entry[kept].last_byte   = last_b;
               shadow_entry[kept].file_tag    = q.tag;
               shadow_entry[kept].src_offset  = q.foff;
               shadow_entry[kept].length      = q.len;
               shadow_entry[kept].generation  = shadow_gen;
               shadow_count = COUNT_W'(kept + 1);
            end
         end
         OP_LOOKUP: begin
            // newest first; a resident image never matches
            if (!q.res) begin
               for (int k = int'(shadow_count) - 1; k >= 0; k--) begin
                  if (shadow_entry[k].file_tag == q.tag &&
                      shadow_entry[k].src_offset == q.foff &&
                      shadow_entry[k].length == q.len) begin
                     r.found = 1'b1;
                     r.slot  = INDEX_W'(k);
                     r.gen   = shadow_entry[k].generation;
                     n_hits++;
                     break;
                  end
               end
            end
         end
         OP_CLEAR: begin
            shadow_count = '0;
            shadow_gen   = '0;
         end
         default: ;
      endcase
      r.count = shadow_count;
      if (int'(shadow_count) > max_fill)
         max_fill = int'(shadow_count);
      return r;
   endfunction

   function automatic stim_row_type stim_row(logic [OP_W-1:0] op, logic [TAG_W-1:0] tag,
                                             logic [FOFF_W-1:0] foff, logic [SEG_W-1:0] seg,
                                             logic [BOFF_W-1:0] boff, logic [LEN_W-1:0] len,
                                             int res, int pin, int fnd,
                                             int slot, logic [GEN_W-1:0] gen,
                                             int cnt);
      stim_row_type s;
      s.req = '{op, tag, foff, seg, boff, len, 1'(res)};
      s.pinned = 1'(pin);
      s.rsp = '{1'(fnd), INDEX_W'(slot), gen, COUNT_W'(cnt)};
      return s;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (idle_mode == 0 || roll < 60)
         return 0;
      else if (roll < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 50);
   endfunction

   function automatic logic [LEN_W-1:0] pick_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 4)
         return '0;
      else if (roll < 74)
         return LEN_W'($urandom_range(1, 256));
      else if (roll < 94)
         return LEN_W'($urandom_range(257, 4096));
      else
         return LEN_W'($urandom);
   endfunction

   // Small pools of tags and offsets so keys repeat across entries.
   function automatic logic [TAG_W-1:0] pick_tag();
      if ($urandom_range(0, 1) == 0)
         return TAG_W'($urandom_range(0, 3)) * 32'h1111_0001;
      else
         return TAG_W'($urandom);
   endfunction

   function automatic logic [FOFF_W-1:0] pick_foff();
      if ($urandom_range(0, 1) == 0)
         return FOFF_W'($urandom_range(0, 3)) * 32'd512;
      else
         return FOFF_W'($urandom);
   endfunction

   function automatic range_req_type make_random_req();
      range_req_type     q;
      int                roll;
      int                pick;
      logic [ADDR_W-1:0] fb;
      q      = '0;
      q.tag  = pick_tag();
      q.foff = pick_foff();
      q.seg  = SEG_W'($urandom);
      q.boff = BOFF_W'($urandom);
      roll   = $urandom_range(0, 99);
      if (roll < 2) begin
         q.op = OP_CLEAR;
      end else if (roll < 4) begin
         q.op  = OP_SPARE;
         q.len = LEN_W'($urandom);
         q.res = 1'($urandom);
      end else if (roll < 40) begin
         q.op  = OP_LOOKUP;
         q.len = pick_len();
         q.res = ($urandom_range(0, 9) == 0);
         // mostly aim at a live entry, sometimes one bit off
         if (shadow_count != '0 && $urandom_range(0, 9) < 7) begin
            pick   = $urandom_range(0, int'(shadow_count) - 1);
            q.tag  = shadow_entry[pick].file_tag;
            q.foff = shadow_entry[pick].src_offset;
            q.len  = shadow_entry[pick].length;
            if ($urandom_range(0, 4) == 0) begin
               case ($urandom_range(0, 2))
                  0: q.tag  = q.tag ^ (32'd1 << $urandom_range(0, 31));
                  1: q.foff = q.foff ^ (32'd1 << $urandom_range(0, 31));
                  default: q.len = q.len ^ (16'd1 << $urandom_range(0, 15));
               endcase
            end
         end
      end else begin
         q.op  = OP_RECORD;
         q.len = pick_len();
         // land on the first byte of a live entry to force an overlap
         if (shadow_count != '0 && $urandom_range(0, 6) == 0) begin
            pick = $urandom_range(0, int'(shadow_count) - 1);
            fb   = shadow_entry[pick].first_byte;
            if (fb[ADDR_W-1]) begin
               q.seg  = '1;
               q.boff = BOFF_W'(fb - 21'h0F_FFF0);
            end else begin
               q.seg  = fb[19:4];
               q.boff = {12'b0, fb[3:0]};
            end
         end
      end
      return q;
   endfunction

   task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      err_count++;
      $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
   endtask

   // Offer one request; called at a falling edge, returns at a falling edge.
   task automatic send_request(range_req_type q, logic pinned, range_rsp_type pinned_rsp);
      int            gap;
      range_rsp_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_operation      = q.op;
      req_file_tag       = q.tag;
      req_file_offset    = q.foff;
      req_segment        = q.seg;
      req_buffer_offset  = q.boff;
      req_read_length    = q.len;
      req_resident_image = q.res;
      req_valid          = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = update_shadow_table(q);
      table_rsp_q.push_back(pinned ? pinned_rsp : predicted);
      case (q.op)
         OP_RECORD: n_records++;
         OP_LOOKUP: n_lookups++;
         OP_CLEAR:  n_clears++;
         default:   n_spare++;
      endcase
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (table_rsp_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // 18 disjoint records in 4 KB steps (fills and overflows the table), then
   // a lookup of each, newest first; the oldest two have been evicted.
   task automatic run_fill_burst();
      range_req_type    q;
      range_req_type    made [$];
      logic [SEG_W-1:0] base;
      base = SEG_W'($urandom);
      for (int k = 0; k < MAX_SLOTS + 2; k++) begin
         q      = '0;
         q.op   = OP_RECORD;
         q.tag  = pick_tag();
         q.foff = pick_foff();
         q.seg  = base + SEG_W'(k * 16'h0100);
         q.boff = BOFF_W'($urandom_range(0, 255));
         q.len  = LEN_W'($urandom_range(1, 3584));
         made.push_back(q);
         send_request(q, 1'b0, '0);
      end
      for (int k = made.size() - 1; k >= 0; k--) begin
         q    = made[k];
         q.op = OP_LOOKUP;
         send_request(q, 1'b0, '0);
      end
   endtask

   // Response checker: one transfer per rising edge with valid high and stall low
   always @(posedge clock) begin
      range_rsp_type w;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (table_rsp_q.size() == 0) begin
            flag_mismatch("response with nothing outstanding", 32'(rsp_entry_count), 32'd0);
         end else begin
            w = table_rsp_q.pop_front();
            n_checked++;
            if (rsp_found !== w.found)
               flag_mismatch("found", 32'(rsp_found), 32'(w.found));
            if (rsp_entry_index !== w.slot)
               flag_mismatch("entry_index", 32'(rsp_entry_index), 32'(w.slot));
            if (rsp_entry_generation !== w.gen)
               flag_mismatch("entry_generation", rsp_entry_generation, w.gen);
            if (rsp_entry_count !== w.count)
               flag_mismatch("entry_count", 32'(rsp_entry_count), 32'(w.count));
         end
      end
   end

   // Receiver: random stall runs, or one long hold-off when asked
   initial begin
      int stall_left;
      int roll;
      rsp_stall  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_asks != hold_seen) begin
            hold_seen  = hold_asks;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else begin
            roll = $urandom_range(0, 99);
            if (idle_mode == 0 || roll < 65) begin
               rsp_stall = 1'b0;
            end else begin
               rsp_stall  = 1'b1;
               stall_left = (roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 60);
            end
         end
      end
   end

   // Watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_operation      = OP_RECORD;
      req_file_tag       = '0;
      req_file_offset    = '0;
      req_segment        = '0;
      req_buffer_offset  = '0;
      req_read_length    = '0;
      req_resident_image = 1'b0;
      shadow_count       = '0;
      shadow_gen         = '0;
      idle_mode          = 1;
      hold_asks          = 0;
      hold_seen          = 0;
      err_count          = 0;
      n_records = 0; n_lookups = 0; n_clears = 0; n_spare = 0;
      n_hits = 0; n_dropped = 0; n_evicted = 0; n_checked = 0; max_fill = 0;

      // Directed rows:       op          tag           foff          seg      boff
      //                      len       res pin fnd slot gen cnt
      dir_rows[0]  = stim_row(OP_LOOKUP, 32'h0,        32'h0,        16'h0,    16'h0,
                              16'h0,    0,  1,  0,  0,  0,  0);   // empty table
      dir_rows[1]  = stim_row(OP_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                              16'h0,    0,  1,  0,  0,  0,  0);   // zero length
      dir_rows[2]  = stim_row(OP_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                              16'hFFFF, 0,  1,  0,  0,  0,  1);   // top of address space
      dir_rows[3]  = stim_row(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0,    16'h0,
                              16'hFFFF, 0,  1,  1,  0,  1,  1);
      dir_rows[4]  = stim_row(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0,    16'h0,
                              16'hFFFF, 1,  1,  0,  0,  0,  1);   // resident image
      dir_rows[5]  = stim_row(OP_RECORD, 32'h0,        32'h0,        16'h0,    16'h0,
                              16'h1,    0,  1,  0,  0,  0,  2);   // byte zero
      dir_rows[6]  = stim_row(OP_LOOKUP, 32'h0,        32'h0,        16'h0,    16'h0,
                              16'h1,    0,  1,  1,  1,  2,  2);
      dir_rows[7]  = stim_row(OP_RECORD, 32'h0,        32'h0,        16'h0,    16'h0,
                              16'h1,    0,  0,  0,  0,  0,  0);   // same range again
      dir_rows[8]  = stim_row(OP_LOOKUP, 32'h0,        32'h0,        16'h0,    16'h0,
                              16'h1,    0,  0,  0,  0,  0,  0);
      dir_rows[9]  = stim_row(OP_RECORD, 32'hFFFF_FFFF, 32'h0,        16'hFFFF, 16'hFFFF,
                              16'h1,    0,  0,  0,  0,  0,  0);   // hits first byte of top
      dir_rows[10] = stim_row(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0,    16'h0,
                              16'hFFFF, 0,  0,  0,  0,  0,  0);
      dir_rows[11] = stim_row(OP_SPARE,  32'hA5A5_5A5A, 32'h5A5A_A5A5, 16'hAAAA, 16'h5555,
                              16'h0F0F, 1,  0,  0,  0,  0,  0);
      dir_rows[12] = stim_row(OP_RECORD, 32'h0000_FFFF, 32'hFFFF_0000, 16'h0,    16'h0,
                              16'hFFFF, 0,  0,  0,  0,  0,  0);   // covers byte zero
      dir_rows[13] = stim_row(OP_CLEAR,  32'h0,        32'h0,        16'h0,    16'h0,
                              16'h0,    0,  1,  0,  0,  0,  0);
      dir_rows[14] = stim_row(OP_LOOKUP, 32'h0,        32'h0,        16'h0,    16'h0,
                              16'h1,    0,  1,  0,  0,  0,  0);
      dir_rows[15] = stim_row(OP_RECORD, 32'h1234_5678, 32'h8000_0000, 16'h8000, 16'h8000,
                              16'h8000, 0,  1,  0,  0,  0,  1);
      dir_rows[16] = stim_row(OP_LOOKUP, 32'h1234_5678, 32'h8000_0000, 16'h0,    16'h0,
                              16'h8000, 0,  1,  1,  0,  1,  1);   // generation restarted
      dir_rows[17] = stim_row(OP_LOOKUP, 32'h1234_5678, 32'h8000_0001, 16'h0,    16'h0,
                              16'h8000, 0,  0,  0,  0,  0,  0);
      dir_rows[18] = stim_row(OP_RECORD, 32'h1234_5678, 32'h8000_0000, 16'h9000, 16'h0,
                              16'h8000, 0,  0,  0,  0,  0,  0);   // adjacent above
      dir_rows[19] = stim_row(OP_LOOKUP, 32'h1234_5678, 32'h8000_0000, 16'h0,    16'h0,
                              16'h8000, 0,  0,  0,  0,  0,  0);   // two matches, newest
      dir_rows[20] = stim_row(OP_RECORD, 32'h0,        32'h0,        16'h8000, 16'h7FF0,
                              16'h10,   0,  0,  0,  0,  0,  0);   // adjacent below
      dir_rows[21] = stim_row(OP_RECORD, 32'h0,        32'h0,        16'h8FFF, 16'hF,
                              16'h1,    0,  0,  0,  0,  0,  0);   // touches last byte
      dir_rows[22] = stim_row(OP_LOOKUP, 32'h1234_5678, 32'h8000_0000, 16'h0,    16'h0,
                              16'h8000, 0,  0,  0,  0,  0,  0);
      dir_rows[23] = stim_row(OP_SPARE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                              16'hFFFF, 1,  0,  0,  0,  0,  0);
      dir_rows[24] = stim_row(OP_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                              16'hFFFF, 1,  1,  0,  0,  0,  0);

      repeat (12) @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i])
         send_request(dir_rows[i].req, dir_rows[i].pinned, dir_rows[i].rsp);
      wait_drained();

      // Random phases: first without idling, the third under a long receiver
      // hold-off so the block backs up and stalls its input. The sender
      // drains completely between phases.
      for (int phase = 0; phase < 4; phase++) begin
         idle_mode = (phase == 0) ? 0 : 1;
         if (phase == 2)
            hold_asks++;
         run_fill_burst();
         repeat (165) send_request(make_random_req(), 1'b0, '0);
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d transfers: %0d records (%0d overlap drops, %0d evictions),",
               n_checked, n_records, n_dropped, n_evicted);
      $display("  %0d lookups (%0d hits), %0d clears, %0d spare ops; peak fill %0d, %0d errors",
               n_lookups, n_hits, n_clears, n_spare, max_fill, err_count);
      if (err_count == 0 && table_rsp_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
